/* rtl/vpe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpe_pkg
// Shared types and constants of the voxel plant-area-density estimator core.
// ----------------------------------------------------------------------------
package vpe_pkg;

    // Fixed-point format of all internal values
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int SRC_W   = 2;
    localparam int CNT_W   = 24;
    localparam int SUM_W   = 32;
    localparam int SQ_W    = 48;
    localparam int GRID_W  = 4;
    localparam int VAL_W   = 48;
    localparam int NGRID   = 13;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_OCC_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_FILL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MASK = 2'd3;

    // Source codes of an input word
    localparam logic [SRC_W-1:0] SRC_THEO   = 2'd0;
    localparam logic [SRC_W-1:0] SRC_BEFORE = 2'd1;
    localparam logic [SRC_W-1:0] SRC_HITS   = 2'd2;

    // Saturation limit of quotients and products (+-2^60)
    localparam logic signed [63:0] LIM_S = 64'sh1000_0000_0000_0000;
    localparam logic [63:0]        LIM_U = 64'h1000_0000_0000_0000;

    // Width of the logarithm argument
    localparam int LN_W = 26;

    typedef enum logic [2:0] {
        OP_DIVF,
        OP_DIVI,
        OP_MUL,
        OP_SQRT,
        OP_LN
    } t_op;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic signed [63:0] res;
    } t_alu_rsp;

endpackage

/* rtl/vpe_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpe_in_if
// Input channel: one voxel grid word with ray count and path-length sums.
// ----------------------------------------------------------------------------
interface vpe_in_if;
    import vpe_pkg::*;

    logic              valid;
    logic              ready;
    logic [SRC_W-1:0]  source;
    logic [CNT_W-1:0]  ray_count;
    logic [SUM_W-1:0]  delta_sum;
    logic [SUM_W-1:0]  eff_delta_sum;
    logic [SQ_W-1:0]   delta_square_sum;
    logic [SUM_W-1:0]  free_sum;
    logic [SUM_W-1:0]  eff_free_sum;
    logic [SUM_W-1:0]  eff_hits_sum;

    modport src (
        output valid, source, ray_count, delta_sum, eff_delta_sum, delta_square_sum,
               free_sum, eff_free_sum, eff_hits_sum,
        input  ready
    );

    modport sink (
        input  valid, source, ray_count, delta_sum, eff_delta_sum, delta_square_sum,
               free_sum, eff_free_sum, eff_hits_sum,
        output ready
    );
endinterface

/* rtl/vpe_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpe_out_if
// Output channel: one estimator or sum word per enabled grid.
// ----------------------------------------------------------------------------
interface vpe_out_if;
    import vpe_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [GRID_W-1:0]        grid_id;
    logic signed [VAL_W-1:0]  value;
    logic                     last;

    modport src (
        output valid, grid_id, value, last,
        input  ready
    );

    modport sink (
        input  valid, grid_id, value, last,
        output ready
    );
endinterface

/* rtl/vpe_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpe_alu
// Shared iterative unit: fixed-point and integer divide (one quotient bit per
// cycle), 64x64 multiply from four 32x32 partial products, floor square root
// (one root bit per cycle) and natural log by repeated squaring.
// ----------------------------------------------------------------------------
module vpe_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vpe_pkg::t_alu_req i_req,
    output vpe_pkg::t_alu_rsp o_rsp
);
    import vpe_pkg::*;

    typedef enum logic [2:0] {
        AS_IDLE,
        AS_DIV,
        AS_MUL,
        AS_SQRT,
        AS_LN,
        AS_LNMUL,
        AS_FIN
    } t_alu_st;

    localparam int             LNK_W    = $clog2(LN_W);
    localparam int             WIDE_ST  = 64;
    localparam int             MUL_ST   = 4;
    localparam int             LN_ST    = 30;
    localparam logic [27:0]    LN2_Q28  = 28'd186065279;

    t_alu_st            r_st;
    t_op                r_op;
    logic [6:0]         r_cnt;
    logic               r_neg;
    logic [63:0]        r_ua;
    logic [63:0]        r_ub;
    logic [65:0]        r_rem;
    logic [127:0]       r_wide;
    logic [63:0]        r_q;
    logic [30:0]        r_m;
    logic [LNK_W-1:0]   r_k;
    logic [29:0]        r_frac;
    logic               r_done;
    logic signed [63:0] r_res;

    // Operand magnitudes and sign
    logic [63:0]  w_ua, w_ub, w_hi, w_lo;
    logic [127:0] w_shl;
    logic         w_neg;

    assign w_ua  = i_req.a[63] ? (64'd0 - 64'(i_req.a)) : 64'(i_req.a);
    assign w_ub  = i_req.b[63] ? (64'd0 - 64'(i_req.b)) : 64'(i_req.b);
    assign w_neg = i_req.a[63] ^ i_req.b[63];
    assign w_shl = {64'd0, w_ua} << FRAC_BITS;
    assign w_hi  = (i_req.op == OP_DIVF) ? w_shl[127:64] : 64'd0;
    assign w_lo  = (i_req.op == OP_DIVF) ? w_shl[63:0]   : w_ua;

    // Log argument normalization
    logic [LN_W-1:0]  w_x;
    logic [LNK_W-1:0] w_k;
    logic [30:0]      w_mn;

    assign w_x = i_req.a[LN_W-1:0];

    always_comb begin
        w_k = '0;
        for (int i = 0; i < LN_W; i++) begin
            if (w_x[i]) begin
                w_k = LNK_W'(i);
            end
        end
    end

    assign w_mn = 31'(w_x) << (LNK_W'(30) - w_k);

    // Divide step
    logic [64:0] w_rr, w_dsub;
    logic        w_dge;

    assign w_rr   = {r_rem[63:0], r_wide[127]};
    assign w_dsub = w_rr - {1'b0, r_ub};
    assign w_dge  = (w_rr >= {1'b0, r_ub});

    // Multiply step
    logic [31:0]  w_pa, w_pb;
    logic [63:0]  w_pp;
    logic [127:0] w_ppx;

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                w_pa  = r_ua[31:0];
                w_pb  = r_ub[31:0];
                w_ppx = {64'd0, w_pp};
            end
            2'd1: begin
                w_pa  = r_ua[31:0];
                w_pb  = r_ub[63:32];
                w_ppx = {32'd0, w_pp, 32'd0};
            end
            2'd2: begin
                w_pa  = r_ua[63:32];
                w_pb  = r_ub[31:0];
                w_ppx = {32'd0, w_pp, 32'd0};
            end
            default: begin
                w_pa  = r_ua[63:32];
                w_pb  = r_ub[63:32];
                w_ppx = {w_pp, 64'd0};
            end
        endcase
    end

    assign w_pp = {32'd0, w_pa} * {32'd0, w_pb};

    // Square root step
    logic [65:0] w_rem2, w_trial;
    logic        w_sge;

    assign w_rem2  = {r_rem[63:0], r_wide[127:126]};
    assign w_trial = {r_q, 2'b01};
    assign w_sge   = (w_rem2 >= w_trial);

    // Log squaring step and final scale
    logic [61:0]  w_sq;
    logic [31:0]  w_s;
    logic [34:0]  w_l2;
    logic [62:0]  w_lp;

    assign w_sq = {31'd0, r_m} * {31'd0, r_m};
    assign w_s  = w_sq[61:30];
    assign w_l2 = {35'(r_k) << 30} | {5'd0, r_frac};
    assign w_lp = {28'd0, w_l2} * {35'd0, LN2_Q28};

    // Final saturation and sign
    logic        w_movf;
    logic [63:0] w_qv, w_qc;

    assign w_movf = |r_wide[127:64+FRAC_BITS];
    assign w_qv   = (r_op == OP_MUL) ? (w_movf ? '1 : r_wide[FRAC_BITS+63:FRAC_BITS]) : r_q;
    assign w_qc   = (w_qv > LIM_U) ? LIM_U : w_qv;

    // Sequence the selected operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= AS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                AS_IDLE: begin
                    if (i_req.start) begin
                        r_op  <= i_req.op;
                        r_cnt <= '0;
                        r_ua  <= w_ua;
                        r_ub  <= w_ub;
                        r_neg <= w_neg && (i_req.op == OP_DIVF || i_req.op == OP_DIVI ||
                                           i_req.op == OP_MUL);
                        case (i_req.op)
                            OP_DIVF, OP_DIVI: begin
                                r_rem  <= {2'b00, w_hi};
                                r_wide <= {w_lo, 64'd0};
                                if (w_hi >= w_ub) begin
                                    r_q  <= '1;
                                    r_st <= AS_FIN;
                                end else begin
                                    r_q  <= '0;
                                    r_st <= AS_DIV;
                                end
                            end
                            OP_MUL: begin
                                r_wide <= '0;
                                r_st   <= AS_MUL;
                            end
                            OP_SQRT: begin
                                r_wide <= w_shl;
                                r_rem  <= '0;
                                r_q    <= '0;
                                r_st   <= AS_SQRT;
                            end
                            OP_LN: begin
                                r_q    <= '0;
                                r_m    <= w_mn;
                                r_k    <= w_k;
                                r_frac <= '0;
                                r_st   <= (w_x == '0) ? AS_FIN : AS_LN;
                            end
                            default: begin
                                r_st <= AS_IDLE;
                            end
                        endcase
                    end
                end
                AS_DIV: begin
                    r_rem  <= {2'b00, (w_dge ? w_dsub[63:0] : w_rr[63:0])};
                    r_wide <= r_wide << 1;
                    r_q    <= {r_q[62:0], w_dge};
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == 7'(WIDE_ST - 1)) begin
                        r_st <= AS_FIN;
                    end
                end
                AS_MUL: begin
                    r_wide <= r_wide + w_ppx;
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == 7'(MUL_ST - 1)) begin
                        r_st <= AS_FIN;
                    end
                end
                AS_SQRT: begin
                    r_rem  <= w_sge ? (w_rem2 - w_trial) : w_rem2;
                    r_q    <= {r_q[62:0], w_sge};
                    r_wide <= r_wide << 2;
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == 7'(WIDE_ST - 1)) begin
                        r_st <= AS_FIN;
                    end
                end
                AS_LN: begin
                    r_m    <= w_s[31] ? w_s[31:1] : w_s[30:0];
                    r_frac <= {r_frac[28:0], w_s[31]};
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == 7'(LN_ST - 1)) begin
                        r_st <= AS_LNMUL;
                    end
                end
                AS_LNMUL: begin
                    r_q  <= 64'(w_lp >> (58 - FRAC_BITS));
                    r_st <= AS_FIN;
                end
                AS_FIN: begin
                    r_done <= 1'b1;
                    r_res  <= r_neg ? $signed(64'd0 - w_qc) : $signed(w_qc);
                    r_st   <= AS_IDLE;
                end
                default: begin
                    r_st <= AS_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

/* rtl/voxel_pad_estimators_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_pad_estimators_core
// Beer-Lambert style plant-area-density estimators for one voxel per three
// input words, computed on one shared iterative arithmetic unit.
// ----------------------------------------------------------------------------
// Send each voxel as three words: theoretical, before, then hits. The first two
// words are only latched. A hits word goes to the occlusion test first; an
// occluded or hit-free voxel then goes straight to output, otherwise 24
// operations run one after another on the shared unit, each issued and then
// awaited until the unit reports done; a divide whose quotient overflows skips
// its bit loop and saturates. Results then leave through the output register,
// one grid id 0 to 12 per cycle while the register is free; a disabled grid
// sends nothing but still takes its cycle. The input is not ready from a hits
// word until its last grid has been handed to the output register.
module voxel_pad_estimators_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vpe_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vpe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    vpe_in_if.sink                          i_in,
    vpe_out_if.src                          o_out
);
    import vpe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OCC,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        SP_I, SP_DM, SP_FM, SP_EFP, SP_EDP, SP_EFH, SP_QQ, SP_LNN,
        SP_LNX, SP_SQ, SP_ALPHA, SP_DEN, SP_CORR, SP_CAP, SP_P, SP_S,
        SP_W, SP_R0, SP_R1, SP_R2, SP_A5, SP_B1, SP_B2, SP_B3
    } t_step;

    localparam int                 NSTEP     = 24;
    localparam logic [GRID_W-1:0]  GRID_LAST = GRID_W'(NGRID - 1);
    localparam logic signed [63:0] ONE       = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] THR_005   = 64'sd5 * ONE / 64'sd100;
    localparam logic signed [63:0] SAT_HI    = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO    = -(64'sd1 <<< (VAL_W - 1));

    localparam logic [GRID_W-1:0] G_BL    = 4'd0;
    localparam logic [GRID_W-1:0] G_CF    = 4'd1;
    localparam logic [GRID_W-1:0] G_MLE   = 4'd2;
    localparam logic [GRID_W-1:0] G_EQBC  = 4'd3;
    localparam logic [GRID_W-1:0] G_UNBC  = 4'd4;
    localparam logic [GRID_W-1:0] G_BCMLE = 4'd5;
    localparam logic [GRID_W-1:0] G_ZS    = 4'd6;
    localparam logic [GRID_W-1:0] G_ZE    = 4'd7;
    localparam logic [GRID_W-1:0] G_DS    = 4'd8;
    localparam logic [GRID_W-1:0] G_DE    = 4'd9;
    localparam logic [GRID_W-1:0] G_DQ    = 4'd10;
    localparam logic [GRID_W-1:0] G_H     = 4'd11;
    localparam logic [GRID_W-1:0] G_I     = 4'd12;

    function automatic logic signed [63:0] clampv(input logic signed [63:0] v);
        if (v > LIM_S) begin
            return LIM_S;
        end else if (v < -LIM_S) begin
            return -LIM_S;
        end
        return v;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat48(input logic signed [63:0] v);
        if (v > SAT_HI) begin
            return VAL_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            return VAL_W'(SAT_LO);
        end
        return VAL_W'(v);
    endfunction

    // Configuration
    logic [CNT_W-1:0]  r_thr;
    logic              r_rel;
    logic [31:0]       r_errf;
    logic [NGRID-1:0]  r_mask;

    // Latched theoretical and before words
    logic [CNT_W-1:0]  r_t_cnt, r_b_cnt;
    logic [SUM_W-1:0]  r_t_d, r_t_e, r_b_d, r_b_e;
    logic [SQ_W-1:0]   r_t_q, r_b_q;

    // Hits word
    logic [CNT_W-1:0]  r_ni;
    logic [SUM_W-1:0]  r_hd, r_he, r_hf, r_hef, r_hh;

    // Control
    t_state            r_state;
    t_step             r_step;
    logic [GRID_W-1:0] r_g;
    logic              r_occ;
    logic              r_fill;
    logic signed [63:0] r_res [0:NSTEP-1];

    // Output register
    logic                    r_ovalid;
    logic [GRID_W-1:0]       r_ogrid;
    logic signed [VAL_W-1:0] r_oval;
    logic                    r_olast;

    t_alu_req w_req;
    t_alu_rsp w_rsp;

    vpe_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Voxel sums
    logic signed [CNT_W:0] w_n;
    logic signed [63:0]    w_n64, w_ni64, w_ds, w_de, w_zs, w_ze, w_dq, w_h;
    logic                  w_ni_lt_n;

    assign w_n       = $signed({1'b0, r_t_cnt}) - $signed({1'b0, r_b_cnt});
    assign w_n64     = 64'(w_n);
    assign w_ni64    = $signed({40'd0, r_ni});
    assign w_ds      = $signed({32'd0, r_t_d}) - $signed({32'd0, r_b_d});
    assign w_de      = $signed({32'd0, r_t_e}) - $signed({32'd0, r_b_e});
    assign w_zs      = $signed({32'd0, r_hf}) + w_ds - $signed({32'd0, r_hd});
    assign w_ze      = $signed({32'd0, r_hef}) + w_de - $signed({32'd0, r_he});
    assign w_dq      = $signed({16'd0, r_t_q}) - $signed({16'd0, r_b_q});
    assign w_h       = $signed({32'd0, r_hh});
    assign w_ni_lt_n = (w_ni64 < w_n64);

    // Occlusion test
    logic signed [49:0] w_n50, w_lhs, w_rhs;
    logic [47:0]        w_thr_nt;
    logic               w_occ;

    assign w_n50    = 50'(w_n);
    assign w_lhs    = w_n50 * 50'sd100;
    assign w_thr_nt = {24'd0, r_thr} * {24'd0, r_t_cnt};
    assign w_rhs    = $signed({2'b00, w_thr_nt});
    assign w_occ    = (r_t_cnt == '0) ||
                      (r_rel ? (w_lhs <= w_rhs) : (w_n50 <= $signed({26'd0, r_thr})));

    // Intermediate values from earlier operations
    logic signed [63:0] w_l, w_vare, w_capnum, w_t, w_one_s, w_errv, w_cap2, w_c;

    assign w_l      = w_ni_lt_n ? (r_res[SP_LNN] - r_res[SP_LNX]) : 64'sd0;
    assign w_vare   = clampv(r_res[SP_QQ] - r_res[SP_SQ]);
    assign w_capnum = w_ni_lt_n ? clampv(w_l - r_res[SP_CORR]) : r_res[SP_LNX];
    assign w_t      = ONE - (r_res[SP_P] <<< 1);
    assign w_one_s  = ONE - r_res[SP_S];
    assign w_errv   = 64'($signed(r_errf));
    assign w_cap2   = r_res[SP_CAP] <<< 1;
    assign w_c      = r_res[SP_A5] - r_res[SP_B3];

    // Operation list
    always_comb begin
        w_req.start = (r_state == ST_ISSUE);
        w_req.op    = OP_DIVF;
        w_req.a     = 64'sd0;
        w_req.b     = w_n64;
        case (r_step)
            SP_I:     begin w_req.a = w_ni64; end
            SP_DM:    begin w_req.op = OP_DIVI; w_req.a = w_ds; end
            SP_FM:    begin w_req.op = OP_DIVI; w_req.a = w_zs; end
            SP_EFP:   begin w_req.op = OP_DIVI; w_req.a = w_ze; end
            SP_EDP:   begin w_req.op = OP_DIVI; w_req.a = w_de; end
            SP_EFH:   begin w_req.op = OP_DIVI; w_req.a = w_h; end
            SP_QQ:    begin w_req.op = OP_DIVI; w_req.a = w_dq; end
            SP_LNN:   begin w_req.op = OP_LN; w_req.a = w_n64; end
            SP_LNX:   begin
                w_req.op = OP_LN;
                w_req.a  = w_ni_lt_n ? (w_n64 - w_ni64) : ((w_n64 <<< 1) + 64'sd2);
            end
            SP_SQ:    begin
                w_req.op = OP_MUL; w_req.a = r_res[SP_EDP]; w_req.b = r_res[SP_EDP];
            end
            SP_ALPHA: begin w_req.a = w_vare; w_req.b = r_res[SP_EDP]; end
            SP_DEN:   begin
                w_req.op = OP_MUL;
                w_req.a  = w_n64 <<< (FRAC_BITS + 1);
                w_req.b  = w_n64 - w_ni64;
            end
            SP_CORR:  begin w_req.a = w_ni64; w_req.b = r_res[SP_DEN]; end
            SP_CAP:   begin w_req.a = w_capnum; w_req.b = r_res[SP_EDP]; end
            SP_P:     begin
                w_req.op = OP_MUL; w_req.a = r_res[SP_ALPHA]; w_req.b = r_res[SP_CAP];
            end
            SP_S:     begin w_req.op = OP_SQRT; w_req.a = w_t; end
            SP_W:     begin w_req.a = w_one_s; w_req.b = r_res[SP_ALPHA]; end
            SP_R0:    begin w_req.a = w_l; w_req.b = r_res[SP_DM]; end
            SP_R1:    begin w_req.a = r_res[SP_I]; w_req.b = r_res[SP_DM]; end
            SP_R2:    begin w_req.a = r_res[SP_I]; w_req.b = r_res[SP_FM]; end
            SP_A5:    begin w_req.a = r_res[SP_I]; w_req.b = r_res[SP_EFP]; end
            SP_B1:    begin w_req.a = r_res[SP_EFH]; w_req.b = r_res[SP_EFP]; end
            SP_B2:    begin w_req.a = r_res[SP_B1]; w_req.b = r_res[SP_EFP]; end
            SP_B3:    begin w_req.op = OP_DIVI; w_req.a = r_res[SP_B2]; end
            default:  begin w_req.op = OP_DIVF; end
        endcase
    end

    // Select the value of the current grid
    logic               w_dm_bad, w_cap_err, w_unbc_ok;
    logic signed [63:0] w_eqbc, w_v;

    assign w_dm_bad  = (r_res[SP_DM] <= 64'sd0);
    assign w_cap_err = (r_res[SP_EDP] <= 64'sd0);
    assign w_eqbc    = w_cap_err ? w_errv : w_cap2;
    assign w_unbc_ok = !w_cap_err && (w_cap2 > w_errv) && (r_res[SP_ALPHA] != 64'sd0) &&
                       (w_t >= THR_005);

    always_comb begin
        if (r_fill) begin
            w_v = r_occ ? w_errv : 64'sd0;
        end else begin
            case (r_g)
                G_BL:    w_v = (w_dm_bad || !w_ni_lt_n) ? w_errv : (r_res[SP_R0] <<< 1);
                G_CF:    w_v = w_dm_bad ? w_errv : (r_res[SP_R1] <<< 1);
                G_MLE:   w_v = (r_res[SP_FM] <= 64'sd0) ? w_errv : (r_res[SP_R2] <<< 1);
                G_EQBC:  w_v = w_eqbc;
                G_UNBC:  w_v = w_unbc_ok ? (r_res[SP_W] <<< 1) : w_eqbc;
                G_BCMLE: begin
                    if (r_res[SP_EFP] <= 64'sd0) begin
                        w_v = w_errv;
                    end else begin
                        w_v = (w_c < 64'sd0) ? 64'sd0 : (w_c <<< 1);
                    end
                end
                G_ZS:    w_v = w_zs;
                G_ZE:    w_v = w_ze;
                G_DS:    w_v = w_ds;
                G_DE:    w_v = w_de;
                G_DQ:    w_v = w_dq;
                G_H:     w_v = w_h;
                G_I:     w_v = r_res[SP_I];
                default: w_v = 64'sd0;
            endcase
        end
    end

    logic w_slot_free, w_last, w_load;

    assign w_slot_free = !r_ovalid || o_out.ready;
    assign w_last      = ((r_mask >> r_g) >> 1) == '0;
    assign w_load      = (r_state == ST_EMIT) && w_slot_free && r_mask[r_g];

    // Control, latches and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= '0;
            r_rel    <= 1'b0;
            r_errf   <= 32'hFFFF_0000;
            r_mask   <= '1;
            r_t_cnt  <= '0;
            r_t_d    <= '0;
            r_t_e    <= '0;
            r_t_q    <= '0;
            r_b_cnt  <= '0;
            r_b_d    <= '0;
            r_b_e    <= '0;
            r_b_q    <= '0;
            r_state  <= ST_IDLE;
            r_step   <= SP_I;
            r_g      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // Take configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OCC_THR:  r_thr  <= i_cfg_data[CNT_W-1:0];
                    CFG_REL_MODE: r_rel  <= i_cfg_data[0];
                    CFG_ERR_FILL: r_errf <= i_cfg_data;
                    CFG_OUT_MASK: r_mask <= i_cfg_data[NGRID-1:0];
                    default:      r_rel  <= r_rel;
                endcase
            end

            // Load the next enabled grid, else drop a delivered word
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        case (i_in.source)
                            SRC_THEO: begin
                                r_t_cnt <= i_in.ray_count;
                                r_t_d   <= i_in.delta_sum;
                                r_t_e   <= i_in.eff_delta_sum;
                                r_t_q   <= i_in.delta_square_sum;
                            end
                            SRC_BEFORE: begin
                                r_b_cnt <= i_in.ray_count;
                                r_b_d   <= i_in.delta_sum;
                                r_b_e   <= i_in.eff_delta_sum;
                                r_b_q   <= i_in.delta_square_sum;
                            end
                            SRC_HITS: begin
                                r_ni    <= i_in.ray_count;
                                r_hd    <= i_in.delta_sum;
                                r_he    <= i_in.eff_delta_sum;
                                r_hf    <= i_in.free_sum;
                                r_hef   <= i_in.eff_free_sum;
                                r_hh    <= i_in.eff_hits_sum;
                                r_state <= ST_OCC;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_OCC: begin
                    r_occ   <= w_occ;
                    r_fill  <= w_occ || (r_ni == '0);
                    r_g     <= '0;
                    r_step  <= SP_I;
                    r_state <= (w_occ || (r_ni == '0)) ? ST_EMIT : ST_ISSUE;
                end
                ST_ISSUE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_rsp.done) begin
                        r_res[r_step] <= w_rsp.res;
                        if (r_step == SP_B3) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_step  <= t_step'(r_step + 5'd1);
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                ST_EMIT: begin
                    // Advance one grid whenever the output register is free
                    if (w_slot_free) begin
                        if (r_mask[r_g]) begin
                            r_ogrid  <= r_g;
                            r_oval   <= sat48(w_v);
                            r_olast  <= w_last;
                        end
                        if (r_g == GRID_LAST) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_g <= r_g + 4'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready    = (r_state == ST_IDLE);
    assign o_out.valid   = r_ovalid;
    assign o_out.grid_id = r_ogrid;
    assign o_out.value   = r_oval;
    assign o_out.last    = r_olast;

    // Unit results arrive only while a result is awaited
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == ST_WAIT))
        else $error("arithmetic result arrived outside the wait state");

    // A held word belongs to an enabled grid
    a_grid_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_mask[r_ogrid])
        else $error("output word for a disabled grid");

    // The last flag marks the highest enabled grid
    a_last_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> (((r_mask >> r_ogrid) >> 1) == '0))
        else $error("last flag set below the highest enabled grid");

endmodule

/* verif/voxel_pad_estimators_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_pad_estimators_checker
// Watches the configuration port and both channels of the estimator core.
// Keeps its own copy of the latched grids and registers, predicts every output
// word of a hits word in fixed point, and compares each output word in order.
// ----------------------------------------------------------------------------
module voxel_pad_estimators_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vpe_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vpe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    vpe_in_if                               i_in,
    vpe_out_if                              i_out,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_voxels,
    output int                              o_results
);
    import vpe_pkg::*;

    localparam longint LIM    = longint'(1) << 60;
    localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
    localparam longint THR_05 = (longint'(5) << FRAC_BITS) / 100;
    localparam longint unsigned LN2_Q28 = 64'd186065279;
    localparam longint unsigned U_MAX   = '1;

    typedef struct {
        logic [GRID_W-1:0]       grid;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_grid_word;

    t_grid_word grid_words_q[$];

    // Register copy
    logic [CNT_W-1:0]  occ_thr;
    logic              rel_mode;
    logic [SUM_W-1:0]  err_fill;
    logic [NGRID-1:0]  out_mask;

    // Latched theoretical and before grids
    logic [CNT_W-1:0]  theo_cnt, bef_cnt;
    logic [SUM_W-1:0]  theo_dl, theo_edl, bef_dl, bef_edl;
    logic [SQ_W-1:0]   theo_sq, bef_sq;

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint mk(longint unsigned m, bit neg);
        longint r;
        r = (m > longint'(LIM)) ? LIM : longint'(m);
        return neg ? -r : r;
    endfunction

    function automatic longint clampv(longint v);
        return v > LIM ? LIM : (v < -LIM ? -LIM : v);
    endfunction

    // Fixed-point quotient, truncated toward zero
    function automatic longint q_div(longint a, longint b);
        logic [127:0] num;
        longint unsigned ua, ub, q;
        ua = mag(a);
        ub = mag(b);
        num = {64'd0, ua} << FRAC_BITS;
        if (ub == 0 || (ua >> (64 - FRAC_BITS)) >= ub) q = U_MAX;
        else q = 64'(num / {64'd0, ub});
        return mk(q, (a < 0) != (b < 0));
    endfunction

    function automatic longint q_mul(longint a, longint b);
        logic [127:0] p;
        longint unsigned q;
        p = {64'd0, mag(a)} * {64'd0, mag(b)};
        if ((p >> (64 + FRAC_BITS)) != 0) q = U_MAX;
        else q = 64'(p >> FRAC_BITS);
        return mk(q, (a < 0) != (b < 0));
    endfunction

    // Floor root of t * 2^F
    function automatic longint q_sqrt(longint t);
        logic [127:0] n, sq;
        longint unsigned r, c;
        n = {64'd0, mag(t)} << FRAC_BITS;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= n) r = c;
        end
        return mk(r, 1'b0);
    endfunction

    // ln(x) from a 30-bit fraction log2, scaled to Q.F
    function automatic longint log_nat(longint unsigned x);
        longint unsigned m, frac, l2;
        logic [127:0] p;
        int k;
        k = 0;
        frac = 0;
        if (x == 0) return 0;
        while (k < 63 && (x >> k) > 1) k++;
        m = (k <= 30) ? x << (30 - k) : x >> (k - 30);
        for (int i = 1; i <= 30; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | (64'd1 << (30 - i));
            end
        end
        l2 = (longint'(k) << 30) | frac;
        p = {64'd0, l2} * {64'd0, LN2_Q28};
        return longint'(64'(p >> (58 - FRAC_BITS)));
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_val(longint v);
        longint mx;
        mx = (longint'(1) << 47) - 1;
        if (v > mx) v = mx;
        if (v < -mx - 1) v = -mx - 1;
        return v[VAL_W-1:0];
    endfunction

    // Predict the output words of one hits word
    task automatic predict_voxel(input logic [CNT_W-1:0] hit_cnt,
                                 input logic [SUM_W-1:0] hit_dl, hit_edl,
                                 input logic [SUM_W-1:0] fr, efr, eh);
        longint est[NGRID];
        longint nt, nb, ni, n, errv, ds, de, zs, ze, dq, hs, ir;
        longint dm, fm, efp, edp, efh, lg, var_e, alpha, cap, corr, tq, a, b, c;
        bit occ, cap_err;
        t_grid_word w;
        int cnt;
        errv = longint'($signed(err_fill));
        nt = theo_cnt;
        nb = bef_cnt;
        ni = hit_cnt;
        n = nt - nb;
        cnt = 0;
        if (nt == 0) occ = 1;
        else if (rel_mode) occ = n * 100 <= longint'(occ_thr) * nt;
        else occ = n <= longint'(occ_thr);

        if (occ || ni == 0) begin
            foreach (est[g]) est[g] = occ ? errv : 0;
        end else begin
            ds = longint'(theo_dl) - longint'(bef_dl);
            de = longint'(theo_edl) - longint'(bef_edl);
            zs = longint'(fr) + ds - longint'(hit_dl);
            ze = longint'(efr) + de - longint'(hit_edl);
            dq = longint'(theo_sq) - longint'(bef_sq);
            hs = longint'(eh);
            ir = q_div(ni, n);
            dm = ds / n;
            fm = zs / n;
            efp = ze / n;
            edp = de / n;
            efh = hs / n;
            lg = (ni < n) ? log_nat(n) - log_nat(n - ni) : 0;
            var_e = clampv(dq / n - q_mul(edp, edp));
            alpha = (edp > 0) ? q_div(var_e, edp) : 0;
            cap = 0;
            cap_err = edp <= 0;

            est[0] = (dm <= 0 || ni >= n) ? errv : 2 * q_div(lg, dm);
            est[1] = (dm <= 0) ? errv : 2 * q_div(ir, dm);
            est[2] = (fm <= 0) ? errv : 2 * q_div(ir, fm);
            if (!cap_err) begin
                if (ni < n) begin
                    corr = q_div(ni, 2 * n * (n - ni));
                    cap = q_div(clampv(lg - corr), edp);
                end else begin
                    cap = q_div(log_nat(2 * n + 2), edp);
                end
            end
            est[3] = cap_err ? errv : 2 * cap;
            est[4] = est[3];
            // Unequal-path bias correction only where the root argument is sane
            if (!cap_err && 2 * cap > errv && alpha != 0) begin
                tq = ONE_Q - 2 * q_mul(alpha, cap);
                if (tq >= THR_05) est[4] = 2 * q_div(ONE_Q - q_sqrt(tq), alpha);
            end
            if (efp <= 0) begin
                est[5] = errv;
            end else begin
                a = q_div(ir, efp);
                b = q_div(q_div(efh, efp), efp) / n;
                c = a - b;
                est[5] = (c < 0) ? 0 : 2 * c;
            end
            est[6] = zs;
            est[7] = ze;
            est[8] = ds;
            est[9] = de;
            est[10] = dq;
            est[11] = hs;
            est[12] = ir;
        end

        // Queue one word per enabled grid, flag the final one
        for (int g = 0; g < NGRID; g++) begin
            if (out_mask[g]) begin
                w.grid = g[GRID_W-1:0];
                w.value = sat_val(est[g]);
                w.last = 1'b0;
                grid_words_q.push_back(w);
                cnt++;
            end
        end
        if (cnt > 0) grid_words_q[grid_words_q.size() - 1].last = 1'b1;
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    // Track registers and input words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            occ_thr <= '0;
            rel_mode <= 1'b0;
            err_fill <= 32'hFFFF_0000;
            out_mask <= '1;
            theo_cnt <= '0; theo_dl <= '0; theo_edl <= '0; theo_sq <= '0;
            bef_cnt <= '0;  bef_dl <= '0;  bef_edl <= '0;  bef_sq <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OCC_THR:  occ_thr <= i_cfg_data[CNT_W-1:0];
                    CFG_REL_MODE: rel_mode <= i_cfg_data[0];
                    CFG_ERR_FILL: err_fill <= i_cfg_data;
                    CFG_OUT_MASK: out_mask <= i_cfg_data[NGRID-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                case (i_in.source)
                    SRC_THEO: begin
                        theo_cnt <= i_in.ray_count;
                        theo_dl <= i_in.delta_sum;
                        theo_edl <= i_in.eff_delta_sum;
                        theo_sq <= i_in.delta_square_sum;
                    end
                    SRC_BEFORE: begin
                        bef_cnt <= i_in.ray_count;
                        bef_dl <= i_in.delta_sum;
                        bef_edl <= i_in.eff_delta_sum;
                        bef_sq <= i_in.delta_square_sum;
                    end
                    SRC_HITS: begin
                        predict_voxel(i_in.ray_count, i_in.delta_sum, i_in.eff_delta_sum,
                                      i_in.free_sum, i_in.eff_free_sum, i_in.eff_hits_sum);
                        o_voxels++;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Compare each output word with the oldest prediction
    always @(posedge i_clk) begin
        t_grid_word w;
        if (i_rst_n && i_out.valid && i_out.ready) begin
            o_results++;
            if (grid_words_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word grid %0d", i_out.grid_id));
            end else begin
                w = grid_words_q.pop_front();
                if (i_out.grid_id !== w.grid)
                    report_mismatch($sformatf("grid_id %0d, want %0d", i_out.grid_id, w.grid));
                if (i_out.value !== w.value)
                    report_mismatch($sformatf("grid %0d value %0d, want %0d",
                                              w.grid, i_out.value, w.value));
                if (i_out.last !== w.last)
                    report_mismatch($sformatf("grid %0d last %0b, want %0b",
                                              w.grid, i_out.last, w.last));
            end
        end
    end

    assign o_pending = grid_words_q.size();

    initial begin
        o_fail_count = 0;
        o_voxels = 0;
        o_results = 0;
    end

endmodule

/* verif/tb_voxel_pad_estimators_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_pad_estimators_core
// Drives voxels (theoretical, before, hits words) into the estimator core
// through several register settings and idle patterns; the checker beside the
// core predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_voxel_pad_estimators_core;
    import vpe_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 2500;
    localparam int ITEM_GOAL   = 160;

    // Source code that the core ignores
    localparam logic [SRC_W-1:0] SRC_UNUSED = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    int                     tx_idle, rx_idle, items_sent, cycles;
    int                     fail_count, pending, voxels, results;

    vpe_in_if  in_ch ();
    vpe_out_if out_ch ();

    voxel_pad_estimators_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    voxel_pad_estimators_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_voxels     (voxels),
        .o_results    (results)
    );

    always #5 i_clk = ~i_clk;

    // Stall the output at random
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    // Give up on a hang
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL voxel_pad_estimators_core");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Send one word, idling at random before it, hold until accepted
    task automatic send_word(input logic [SRC_W-1:0] src, input logic [CNT_W-1:0] cnt,
                             input logic [SUM_W-1:0] dl, edl, input logic [SQ_W-1:0] sq,
                             input logic [SUM_W-1:0] fr, efr, eh);
        while ($urandom_range(99) < tx_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.source <= src;
        in_ch.ray_count <= cnt;
        in_ch.delta_sum <= dl;
        in_ch.eff_delta_sum <= edl;
        in_ch.delta_square_sum <= sq;
        in_ch.free_sum <= fr;
        in_ch.eff_free_sum <= efr;
        in_ch.eff_hits_sum <= eh;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_raw_word(input logic [SRC_W-1:0] src);
        send_word(src, CNT_W'($urandom), $urandom, $urandom, SQ_W'({$urandom, $urandom}),
                  $urandom, $urandom, $urandom);
    endtask

    // One voxel: mostly plausible ray statistics, sometimes raw or broken
    task automatic send_voxel();
        longint unsigned nt, nb, ni, n, lr, le;
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            send_raw_word(SRC_THEO);
            send_raw_word(SRC_BEFORE);
            send_raw_word(SRC_HITS);
            return;
        end
        nt = 64'($urandom_range(1, 2000));
        nb = 64'($urandom_range(0, 32'(nt)));
        n = nt - nb;
        case ($urandom_range(3))
            0: ni = 0;
            1: ni = n;
            default: ni = 64'($urandom_range(0, 32'(n)));
        endcase
        lr = 64'($urandom_range(32'h800, 32'h30000));
        le = 64'($urandom_range(32'h400, 32'(lr)));
        if (pick < 20) send_raw_word(SRC_UNUSED);
        // drop the theoretical or before word now and then
        if (pick < 90 || pick >= 95)
            send_word(SRC_THEO, CNT_W'(nt), SUM_W'(nt * lr), SUM_W'(nt * le),
                      SQ_W'(nt * ((lr * 64'($urandom_range(32'(lr), 32'(lr) + 32'h4000)))
                                  >> 16)),
                      '0, '0, '0);
        if (pick < 95)
            send_word(SRC_BEFORE, CNT_W'(nb), SUM_W'(nb * lr), SUM_W'(nb * le),
                      SQ_W'(nb * ((lr * lr) >> 16)), '0, '0, '0);
        send_word(SRC_HITS, CNT_W'(ni), SUM_W'((ni * lr) >> 1), SUM_W'((ni * le) >> 1), '0,
                  $urandom_range(0, 32'(n * lr)), $urandom_range(0, 32'(n * le)),
                  SUM_W'((ni * le) >> 1));
    endtask

    // Let the core finish and settle before touching registers
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [31:0] thr, rel, err, mask);
        write_reg(CFG_OCC_THR, thr);
        write_reg(CFG_REL_MODE, rel);
        write_reg(CFG_ERR_FILL, err);
        write_reg(CFG_OUT_MASK, mask);
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.source = '0;
        in_ch.ray_count = '0;
        in_ch.delta_sum = '0;
        in_ch.eff_delta_sum = '0;
        in_ch.delta_square_sum = '0;
        in_ch.free_sum = '0;
        in_ch.eff_free_sum = '0;
        in_ch.eff_hits_sum = '0;
        out_ch.ready = 1'b0;
        cycles = 0;
        items_sent = 0;
        tx_idle = 25;
        rx_idle = 79;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: nothing latched yet, so the voxel is occluded
        send_word(SRC_HITS, 24'd5, 32'd1, 32'd1, '0, 32'd1, 32'd1, 32'd1);
        send_raw_word(SRC_UNUSED);
        // no hits
        send_word(SRC_THEO, 24'd100, 32'h0064_0000, 32'h0050_0000, 48'h0064_0000,
                  '0, '0, '0);
        send_word(SRC_BEFORE, 24'd20, 32'h0014_0000, 32'h0010_0000, 48'h0014_0000,
                  '0, '0, '0);
        send_word(SRC_HITS, 24'd0, '0, '0, '0, 32'h0030_0000, 32'h0020_0000, '0);
        // hits equal to the remaining rays
        send_word(SRC_HITS, 24'd80, 32'h0010_0000, 32'h0008_0000, '0,
                  32'h0020_0000, 32'h0018_0000, 32'h0020_0000);
        // ordinary voxel
        send_word(SRC_HITS, 24'd30, 32'h000F_0000, 32'h000C_0000, '0,
                  32'h0030_0000, 32'h0028_0000, 32'h000C_0000);
        // all ones against all zeros
        send_word(SRC_THEO, '1, '1, '1, '1, '1, '1, '1);
        send_word(SRC_BEFORE, '0, '0, '0, '0, '0, '0, '0);
        send_word(SRC_HITS, '1, '1, '1, '1, '1, '1, '1);
        send_word(SRC_HITS, 24'd1, '0, '0, '0, '0, '0, '0);
        // zero mean path length
        send_word(SRC_BEFORE, 24'd10, '1, '1, '1, '0, '0, '0);
        send_word(SRC_HITS, 24'd3, '0, '0, '0, '1, '1, '1);
        drain();

        // Random voxels over a sweep of register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_regs($urandom_range(0, 40), 32'd0, 32'hFFFF_0000, 32'h1FFF);
                1: set_regs(32'hFF_FFFF, 32'd0, 32'h7FFF_FFFF, $urandom);
                2: set_regs($urandom_range(0, 60), 32'd1, 32'h8000_0000, 32'h1FFF);
                3: set_regs(32'd0, 32'd1, 32'h0000_0000, 32'h0000);
                4: set_regs(32'd100, 32'd1, $urandom, 32'h1000);
                default: set_regs(32'd0, 32'd0, $urandom, 32'h1FFF);
            endcase
            tx_idle = (ph < 2) ? 25 : (ph < 4) ? 79 : 0;
            rx_idle = (ph < 2) ? 79 : (ph < 4) ? 25 : 0;
            while (items_sent < (ph + 1) * ITEM_GOAL / 6) send_voxel();
            drain();
        end

        $display("Covered %0d words in, %0d hits voxels, %0d output words checked.",
                 items_sent, voxels, results);
        $display("Settings: absolute and percent thresholds, error fills, grid masks.");
        if (fail_count == 0) begin
            $display("PASS voxel_pad_estimators_core");
        end else begin
            $display("FAIL voxel_pad_estimators_core");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/vpe_pkg.sv
rtl/vpe_in_if.sv
rtl/vpe_out_if.sv
rtl/vpe_alu.sv
rtl/voxel_pad_estimators_core.sv
verif/voxel_pad_estimators_checker.sv
verif/tb_voxel_pad_estimators_core.sv
